// ----- rtl/text_console_writer_macros.svh -----
// ============================================================================
// text_console_writer_macros.svh
// Assertion macros shared by the text console RTL.
// ============================================================================
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, off while reset is high
`define TCW_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define TCW_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/tcw_pkg.sv -----
// ============================================================================
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ============================================================================
package tcw_pkg;

   // Default grid size
   localparam int COLS_DEFAULT  = 80;
   localparam int ROWS_DEFAULT  = 25;
   localparam int QUEUE_DEPTH   = 2;

   // Field widths
   localparam int MODE_W        = 2;
   localparam int CHAR_W        = 8;
   localparam int POS_IN_W      = 8;
   localparam int CUR_ROW_W     = 5;
   localparam int CUR_COL_W     = 7;
   localparam int CUR_OFFSET_W  = 11;
   localparam int CELL_W        = 16;
   localparam int ATTR_W        = 8;
   localparam int COLOR_W       = 4;

   // Config port
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = COLOR_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FORE_COLOR = 1'b0,
      CSR_BACK_COLOR = 1'b1
   } csr_index_type;

   localparam logic [COLOR_W-1:0] FORE_RESET = 4'h7;
   localparam logic [COLOR_W-1:0] BACK_RESET = 4'h0;

   // Characters
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

   // Grey space on black
   localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;

   localparam int TAB_STEP = 8;

   // Request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_PUT   = 2'd0,
      MODE_SET   = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   // Classified operations
   typedef enum logic [2:0] {
      OP_PRINT     = 3'd0,
      OP_NEWLINE   = 3'd1,
      OP_RETURN    = 3'd2,
      OP_BACKSPACE = 3'd3,
      OP_TAB       = 3'd4,
      OP_SET       = 3'd5,
      OP_CLEAR     = 3'd6,
      OP_READ      = 3'd7
   } op_type;

   // Queue entry between front and back
   typedef struct packed {
      op_type                op;
      logic [CHAR_W-1:0]     ch;
      logic [POS_IN_W-1:0]   row;
      logic [POS_IN_W-1:0]   col;
   } cmd_type;

endpackage

// ----- rtl/tcw_if.sv -----
// ============================================================================
// tcw_if
// Request and response channel interfaces (valid/ready).
// ============================================================================
interface tcw_req_if;
   logic                            valid;
   logic                            ready;
   logic [tcw_pkg::MODE_W-1:0]      mode;
   logic [tcw_pkg::CHAR_W-1:0]      char_code;
   logic [tcw_pkg::POS_IN_W-1:0]    row_in;
   logic [tcw_pkg::POS_IN_W-1:0]    col_in;

   modport source (output valid, mode, char_code, row_in, col_in, input ready);
   modport sink   (input valid, mode, char_code, row_in, col_in, output ready);
endinterface

interface tcw_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [tcw_pkg::CUR_ROW_W-1:0]      cursor_row;
   logic [tcw_pkg::CUR_COL_W-1:0]      cursor_col;
   logic [tcw_pkg::CUR_OFFSET_W-1:0]   cursor_offset;
   logic [tcw_pkg::CELL_W-1:0]         cell_value;
   logic                               did_scroll;

   modport source (output valid, cursor_row, cursor_col, cursor_offset, cell_value,
                   did_scroll, input ready);
   modport sink   (input valid, cursor_row, cursor_col, cursor_offset, cell_value,
                   did_scroll, output ready);
endinterface

// ----- rtl/tcw_front.sv -----
// ============================================================================
// tcw_front
// Request intake: decodes mode and control characters, clamps positions.
// ============================================================================
module tcw_front #(
   parameter int COLS = tcw_pkg::COLS_DEFAULT,
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
   tcw_req_if.sink            req_ch,
   input  logic               init_busy,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output tcw_pkg::cmd_type   cmd
);
   import tcw_pkg::*;

   logic [POS_IN_W:0] row_wide;
   logic [POS_IN_W:0] col_wide;

   // No intake while the power-up clearing pass runs
   assign req_ch.ready = cmd_ready && !init_busy;
   assign cmd_valid    = req_ch.valid && !init_busy;

   // Clamp to the last row / column
   assign row_wide = {1'b0, req_ch.row_in};
   assign col_wide = {1'b0, req_ch.col_in};

   always_comb begin
      cmd.ch  = req_ch.char_code;
      cmd.row = (row_wide >= (POS_IN_W+1)'(ROWS)) ? POS_IN_W'(ROWS - 1) : req_ch.row_in;
      cmd.col = (col_wide >= (POS_IN_W+1)'(COLS)) ? POS_IN_W'(COLS - 1) : req_ch.col_in;
      cmd.op  = OP_PRINT;
      unique case (mode_type'(req_ch.mode))
         MODE_PUT: begin
            case (req_ch.char_code)
               CH_NEWLINE:   cmd.op = OP_NEWLINE;
               CH_RETURN:    cmd.op = OP_RETURN;
               CH_BACKSPACE: cmd.op = OP_BACKSPACE;
               CH_TAB:       cmd.op = OP_TAB;
               default:      cmd.op = OP_PRINT;
            endcase
         end
         MODE_SET:   cmd.op = OP_SET;
         MODE_CLEAR: cmd.op = OP_CLEAR;
         MODE_READ:  cmd.op = OP_READ;
      endcase
   end

endmodule

// ----- rtl/tcw_fifo.sv -----
// ============================================================================
// tcw_fifo
// Short command queue between intake and execution.
// ============================================================================
`include "text_console_writer_macros.svh"

module tcw_fifo #(
   parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  tcw_pkg::cmd_type   in_cmd,
   output logic               out_valid,
   input  logic               out_ready,
   output tcw_pkg::cmd_type   out_cmd
);
   import tcw_pkg::*;

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type           slots_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff < CntW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   `TCW_ASSERT_NOW(a_fifo_count_max, clock, reset, 1'b1, count_ff <= CntW'(DEPTH), "queue overfilled")
   `TCW_ASSERT_NOW(a_fifo_empty_ptrs, clock, reset, count_ff == '0, rd_ptr_ff == wr_ptr_ff, "empty queue with split pointers")
   `TCW_ASSERT_NEXT(a_fifo_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "push not counted")

endmodule

// ----- rtl/tcw_back.sv -----
// ============================================================================
// tcw_back
// Command execution: cursor, screen memory, scroll/clear sweeps, responses.
// ============================================================================
`include "text_console_writer_macros.svh"

module tcw_back #(
   parameter int COLS = tcw_pkg::COLS_DEFAULT,
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  tcw_pkg::cmd_type             cmd,
   input  logic [tcw_pkg::ATTR_W-1:0]   attr,
   output logic                         init_busy,
   tcw_rsp_if.source                    rsp_ch
);
   import tcw_pkg::*;

   localparam int CellCount = ROWS * COLS;
   localparam int CopyEnd   = CellCount - COLS;
   localparam int AddrW     = $clog2(CellCount);
   localparam int ScanW     = $clog2(CellCount + 1);
   localparam int RowW      = $clog2(ROWS);
   localparam int ColW      = $clog2(COLS);
   localparam logic [RowW-1:0] LastRow = RowW'(ROWS - 1);
   localparam logic [ColW-1:0] LastCol = ColW'(COLS - 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_FILL   = 4'b0010,
      S_SCROLL = 4'b0100,
      S_READ   = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [ScanW-1:0]    scan_ff, scan_in;
   logic [CELL_W-1:0]   fill_value_ff, fill_value_in;
   logic                fill_reply_ff, fill_reply_in;
   logic [RowW-1:0]     row_ff, row_in;
   logic [ColW-1:0]     col_ff, col_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CUR_ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [CUR_COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [CUR_OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [CELL_W-1:0]       rsp_cell_ff, rsp_cell_in;
   logic                    rsp_scroll_ff, rsp_scroll_in;

   logic [CELL_W-1:0]   cells_ff [CellCount];
   logic [CELL_W-1:0]   rd_data_ff;
   logic                mem_we;
   logic [AddrW-1:0]    mem_waddr, mem_raddr;
   logic [CELL_W-1:0]   mem_wdata;

   logic                out_free, pop;
   logic                adv_row, resp_set, resp_scroll, resp_cell_sel;
   logic [ColW:0]       col_inc, col_tab;
   logic [ScanW-1:0]    scan_src, scan_prev;
   logic [RowW-1:0]     wr_row;
   logic [ColW-1:0]     wr_col;
   logic [AddrW-1:0]    wr_addr, read_addr, cur_offset;
   logic [31:0]         row_wide, col_wide, offset_wide;

   // Handshake toward the queue
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign cmd_ready = (state_ff == S_IDLE) && out_free;
   assign pop       = cmd_ready && cmd_valid;
   assign init_busy = (state_ff == S_FILL) && !fill_reply_ff;

   // Cursor arithmetic
   assign col_inc   = {1'b0, col_ff} + 1'b1;
   assign col_tab   = ({1'b0, col_ff} + (ColW+1)'(TAB_STEP)) & ~(ColW+1)'(TAB_STEP - 1);
   assign scan_src  = scan_ff + ScanW'(COLS);
   assign scan_prev = scan_ff - 1'b1;
   assign read_addr = AddrW'(cmd.row[RowW-1:0]) * AddrW'(COLS) + AddrW'(cmd.col[ColW-1:0]);
   assign wr_addr   = AddrW'(wr_row) * AddrW'(COLS) + AddrW'(wr_col);
   assign cur_offset = AddrW'(row_in) * AddrW'(COLS) + AddrW'(col_in);

   // Control: cursor update, memory port use, sweep sequencing
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      fill_value_in = fill_value_ff;
      fill_reply_in = fill_reply_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      adv_row       = 1'b0;
      resp_set      = 1'b0;
      resp_scroll   = 1'b0;
      resp_cell_sel = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_raddr     = '0;
      wr_row        = row_ff;
      wr_col        = col_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop) begin
               resp_set = 1'b1;
               case (cmd.op)
                  OP_NEWLINE: begin
                     col_in  = '0;
                     adv_row = 1'b1;
                  end
                  OP_RETURN: col_in = '0;
                  OP_BACKSPACE: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                     end else if (row_ff != '0) begin
                        row_in = row_ff - 1'b1;
                        col_in = LastCol;
                     end
                     // blank lands on the new position
                     wr_row    = row_in;
                     wr_col    = col_in;
                     mem_we    = 1'b1;
                     mem_wdata = {attr, BLANK_CHAR};
                  end
                  OP_TAB: begin
                     if (col_tab >= (ColW+1)'(COLS)) begin
                        col_in  = '0;
                        adv_row = 1'b1;
                     end else begin
                        col_in = col_tab[ColW-1:0];
                     end
                  end
                  OP_PRINT: begin
                     mem_we    = 1'b1;
                     mem_wdata = {attr, cmd.ch};
                     if (col_inc >= (ColW+1)'(COLS)) begin
                        col_in  = '0;
                        adv_row = 1'b1;
                     end else begin
                        col_in = col_inc[ColW-1:0];
                     end
                  end
                  OP_SET: begin
                     row_in = cmd.row[RowW-1:0];
                     col_in = cmd.col[ColW-1:0];
                  end
                  OP_CLEAR: begin
                     row_in        = '0;
                     col_in        = '0;
                     resp_set      = 1'b0;
                     state_in      = S_FILL;
                     scan_in       = '0;
                     fill_value_in = {attr, BLANK_CHAR};
                     fill_reply_in = 1'b1;
                  end
                  OP_READ: begin
                     resp_set  = 1'b0;
                     mem_raddr = read_addr;
                     state_in  = S_READ;
                  end
               endcase
               mem_waddr = wr_addr;
               // Row advance, scrolling off the bottom
               if (adv_row) begin
                  if (row_ff == LastRow) begin
                     resp_set = 1'b0;
                     state_in = S_SCROLL;
                     scan_in  = '0;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff[AddrW-1:0];
            mem_wdata = fill_value_ff;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == ScanW'(CellCount - 1)) begin
               state_in = S_IDLE;
               resp_set = fill_reply_ff;
            end
         end
         S_SCROLL: begin
            // read one row ahead, write the word read last cycle
            if (scan_ff < ScanW'(CopyEnd)) begin
               mem_raddr = scan_src[AddrW-1:0];
            end
            if (scan_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = scan_prev[AddrW-1:0];
               mem_wdata = (scan_prev < ScanW'(CopyEnd)) ? rd_data_ff : {attr, BLANK_CHAR};
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == ScanW'(CellCount)) begin
               state_in    = S_IDLE;
               scan_in     = '0;
               resp_set    = 1'b1;
               resp_scroll = 1'b1;
            end
         end
         S_READ: begin
            state_in      = S_IDLE;
            resp_set      = 1'b1;
            resp_cell_sel = 1'b1;
         end
      endcase
   end

   // Response register
   assign row_wide    = 32'(row_in);
   assign col_wide    = 32'(col_in);
   assign offset_wide = 32'(cur_offset);

   always_comb begin
      rsp_valid_in  = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_scroll_in = rsp_scroll_ff;
      if (resp_set) begin
         rsp_valid_in  = 1'b1;
         rsp_row_in    = row_wide[CUR_ROW_W-1:0];
         rsp_col_in    = col_wide[CUR_COL_W-1:0];
         rsp_offset_in = offset_wide[CUR_OFFSET_W-1:0];
         rsp_cell_in   = resp_cell_sel ? rd_data_ff : '0;
         rsp_scroll_in = resp_scroll;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_FILL;
         scan_ff       <= '0;
         fill_value_ff <= RESET_CELL;
         fill_reply_ff <= 1'b0;
         row_ff        <= '0;
         col_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         fill_value_ff <= fill_value_in;
         fill_reply_ff <= fill_reply_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_scroll_ff <= rsp_scroll_in;
   end

   // Screen memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= cells_ff[mem_raddr];
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.cursor_row    = rsp_row_ff;
   assign rsp_ch.cursor_col    = rsp_col_ff;
   assign rsp_ch.cursor_offset = rsp_offset_ff;
   assign rsp_ch.cell_value    = rsp_cell_ff;
   assign rsp_ch.did_scroll    = rsp_scroll_ff;

   `TCW_ASSERT_NOW(a_back_cursor_range, clock, reset, 1'b1, (row_ff <= LastRow) && (col_ff <= LastCol), "cursor off the grid")
   `TCW_ASSERT_NOW(a_back_scroll_row, clock, reset, rsp_valid_ff && rsp_scroll_ff, row_ff == LastRow, "scroll reply off the last row")
   `TCW_ASSERT_NOW(a_back_busy_no_rsp, clock, reset, state_ff != S_IDLE, !rsp_valid_ff, "reply pending during a sweep")
   `TCW_ASSERT_NOW(a_back_scan_bound, clock, reset, 1'b1, scan_ff <= ScanW'(CellCount), "sweep ran past the grid")

endmodule

// ----- rtl/text_console_writer.sv -----
// ============================================================================
// text_console_writer
// Text-mode console: character grid, cursor, scroll, clear and cell readout.
// ============================================================================
// Usage:
//   req_ch carries one item per valid/ready handshake: mode, char_code,
//   row_in, col_in. rsp_ch returns exactly one item per request, in order,
//   with the cursor, its linear offset, the cell read and a scroll flag.
//   csr_we/csr_index/csr_wdata set the foreground and background colors;
//   write them only while no request is in flight.
// Timing:
//   Put, set cursor and control characters execute as they are taken and
//   write the reply straight into the output register, unless the cursor
//   runs off the bottom row, which first runs a scroll. Read cell passes
//   through a read state for the registered memory read. Clear sweeps the
//   memory one cell a cycle. A scroll copies the grid up through the single
//   read and write port.
//   A two-entry queue lets requests be taken while the executor is busy.
// Reset:
//   Cursor goes to 0,0, colors to grey on black, and the grid is cleared to
//   0x0720 in a pass over all ROWS*COLS cells with req_ch.ready held low.
// Stalls:
//   While rsp_ch.ready is low a pending reply holds and no new command is
//   started; intake continues until the queue is full.
// ============================================================================
module text_console_writer #(
   parameter int COLS        = tcw_pkg::COLS_DEFAULT,
   parameter int ROWS        = tcw_pkg::ROWS_DEFAULT,
   parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   tcw_req_if.sink                           req_ch,
   tcw_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tcw_pkg::*;

   logic [COLOR_W-1:0] fore_ff, fore_in;
   logic [COLOR_W-1:0] back_ff, back_in;
   logic [ATTR_W-1:0]  attr;
   logic               cmd_valid, cmd_ready;
   logic               q_valid, q_ready;
   logic               init_busy;
   cmd_type            cmd, q_cmd;

   // Color registers
   always_comb begin
      fore_in = fore_ff;
      back_in = back_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FORE_COLOR: fore_in = csr_wdata;
            CSR_BACK_COLOR: back_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fore_ff <= FORE_RESET;
         back_ff <= BACK_RESET;
      end else begin
         fore_ff <= fore_in;
         back_ff <= back_in;
      end
   end

   assign attr = {back_ff, fore_ff};

   tcw_front #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_front (
      .req_ch    (req_ch),
      .init_busy (init_busy),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   tcw_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmd_valid),
      .in_ready  (cmd_ready),
      .in_cmd    (cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   tcw_back #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .attr      (attr),
      .init_busy (init_busy),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- verif/console_screen_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_screen_checker
// Passive checker for the text console writer. It watches the request,
// response and color-register ports, keeps its own copy of the character
// grid, cursor and colors, predicts one response per accepted request and
// compares each accepted response against the oldest prediction.
// ----------------------------------------------------------------------------
module console_screen_checker (
   input  logic                             clock,
   input  logic                             reset,
   tcw_req_if                               req_ch,
   tcw_rsp_if                               rsp_ch,
   input  logic                             csr_we,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               fail_count,
   output int                               pending_count
);
   import tcw_pkg::*;

   localparam int COLS       = COLS_DEFAULT;
   localparam int ROWS       = ROWS_DEFAULT;
   localparam int CELLS      = COLS * ROWS;
   localparam int MAX_REPORT = 10;

   typedef struct packed {
      logic [CUR_ROW_W-1:0]    row;
      logic [CUR_COL_W-1:0]    col;
      logic [CUR_OFFSET_W-1:0] offset;
      logic [CELL_W-1:0]       cell_word;
      logic                    scrolled;
   } cursor_report_type;

   // Mirror of the console state
   logic [CELL_W-1:0]  grid [0:CELLS-1];
   int                 cur_r;
   int                 cur_c;
   logic [COLOR_W-1:0] fg_color;
   logic [COLOR_W-1:0] bg_color;

   cursor_report_type  expected_reports [$];
   cursor_report_type  got_report;
   cursor_report_type  want_report;
   int                 mismatches;
   int                 outstanding;

   assign fail_count    = mismatches;
   assign pending_count = outstanding;

   function automatic logic [CELL_W-1:0] colored_cell(logic [CHAR_W-1:0] ch);
      return {bg_color, fg_color, ch};
   endfunction

   function automatic int clamp_index(int v, int lim);
      return (v >= lim) ? lim - 1 : v;
   endfunction

   // Move every row up one and blank the last row in the current colors
   function automatic void scroll_grid_up();
      for (int i = 0; i < CELLS - COLS; i++) grid[i] = grid[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) grid[i] = colored_cell(BLANK_CHAR);
   endfunction

   // Apply one request to the mirror and return the report it should give
   function automatic cursor_report_type advance_console(mode_type m, logic [CHAR_W-1:0] ch,
                                                         logic [POS_IN_W-1:0] r,
                                                         logic [POS_IN_W-1:0] c);
      cursor_report_type res;
      res = '0;
      case (m)
         MODE_PUT: begin
            case (ch)
               CH_NEWLINE: begin
                  cur_c = 0;
                  cur_r++;
               end
               CH_RETURN: cur_c = 0;
               CH_BACKSPACE: begin
                  // back one cell, wrap to end of row above, stay at top-left
                  if (cur_c > 0) cur_c--;
                  else if (cur_r > 0) begin
                     cur_r--;
                     cur_c = COLS - 1;
                  end
                  grid[cur_r * COLS + cur_c] = colored_cell(BLANK_CHAR);
               end
               CH_TAB: begin
                  cur_c = (cur_c + TAB_STEP) & ~(TAB_STEP - 1);
                  if (cur_c >= COLS) begin
                     cur_c = 0;
                     cur_r++;
                  end
               end
               default: begin
                  grid[cur_r * COLS + cur_c] = colored_cell(ch);
                  cur_c++;
                  if (cur_c >= COLS) begin
                     cur_c = 0;
                     cur_r++;
                  end
               end
            endcase
            // ran off the bottom: scroll, cursor stays on the last row
            if (cur_r >= ROWS) begin
               scroll_grid_up();
               cur_r = ROWS - 1;
               res.scrolled = 1'b1;
            end
         end
         MODE_SET: begin
            cur_r = clamp_index(int'(r), ROWS);
            cur_c = clamp_index(int'(c), COLS);
         end
         MODE_CLEAR: begin
            for (int i = 0; i < CELLS; i++) grid[i] = colored_cell(BLANK_CHAR);
            cur_r = 0;
            cur_c = 0;
         end
         MODE_READ: begin
            res.cell_word = grid[clamp_index(int'(r), ROWS) * COLS
                                 + clamp_index(int'(c), COLS)];
         end
      endcase
      res.row    = CUR_ROW_W'(cur_r);
      res.col    = CUR_COL_W'(cur_c);
      res.offset = CUR_OFFSET_W'(cur_r * COLS + cur_c);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CELLS; i++) grid[i] = RESET_CELL;
         cur_r = 0;
         cur_c = 0;
         fg_color = FORE_RESET;
         bg_color = BACK_RESET;
         expected_reports.delete();
         outstanding = 0;
         mismatches = 0;
      end else begin
         // color registers
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_FORE_COLOR: fg_color = csr_wdata;
               CSR_BACK_COLOR: bg_color = csr_wdata;
               default: ;
            endcase
         end

         // response side: compare with the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_report.row       = rsp_ch.cursor_row;
            got_report.col       = rsp_ch.cursor_col;
            got_report.offset    = rsp_ch.cursor_offset;
            got_report.cell_word = rsp_ch.cell_value;
            got_report.scrolled  = rsp_ch.did_scroll;
            if (expected_reports.size() == 0) begin
               if (mismatches < MAX_REPORT)
                  $display("%0t: response with no request pending: row %0d col %0d",
                           $realtime, got_report.row, got_report.col);
               mismatches++;
            end else begin
               want_report = expected_reports.pop_front();
               outstanding--;
               if (got_report !== want_report) begin
                  if (mismatches < MAX_REPORT) begin
                     $display("%0t: mismatch: expected row %0d col %0d offset %0d cell %h scroll %b",
                              $realtime, want_report.row, want_report.col,
                              want_report.offset, want_report.cell_word,
                              want_report.scrolled);
                     $display("   got row %0d col %0d offset %0d cell %h scroll %b",
                              got_report.row, got_report.col, got_report.offset,
                              got_report.cell_word, got_report.scrolled);
                  end
                  mismatches++;
               end
            end
         end

         // request side: predict on acceptance
         if (req_ch.valid && req_ch.ready) begin
            expected_reports.push_back(advance_console(mode_type'(req_ch.mode),
                                                       req_ch.char_code,
                                                       req_ch.row_in, req_ch.col_in));
            outstanding++;
         end
      end
   end

endmodule

// ----- verif/text_console_writer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Top of the text console writer testbench. Drives directed and random
// console requests with random gaps on both channels, a long response
// hold-off that backs up the request side, and color register changes
// between phases. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int     ROWS        = ROWS_DEFAULT;
   localparam int     COLS        = COLS_DEFAULT;
   localparam int     LONG_HOLD   = 300;
   localparam int     DRAIN_WAIT  = 100;
   localparam longint TIMEOUT_NS  = 400_000_000;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int fail_count;
   int pending_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int holds_served;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   text_console_writer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   console_screen_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_bus),
      .rsp_ch        (rsp_bus),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Run limit
   initial begin
      #(TIMEOUT_NS);
      $display("text_console_writer_tb: FAIL");
      $finish;
   end

   // Response side: random ready, with a long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            holds_served++;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Offer one item; called and returns at a falling edge
   task automatic send_item(mode_type m, logic [CHAR_W-1:0] ch,
                            logic [POS_IN_W-1:0] r, logic [POS_IN_W-1:0] c);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= m;
      req_bus.char_code <= ch;
      req_bus.row_in    <= r;
      req_bus.col_in    <= c;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering and wait until every response is back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic set_colors(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
      csr_we    <= 1'b1;
      csr_index <= CSR_FORE_COLOR;
      csr_wdata <= fg;
      @(negedge clock);
      csr_index <= CSR_BACK_COLOR;
      csr_wdata <= bg;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Half the positions land on the grid, half anywhere in the byte range
   function automatic logic [POS_IN_W-1:0] aim_pos(int lim);
      return POS_IN_W'($urandom_range(0, 1) ? $urandom_range(0, lim - 1)
                                            : $urandom_range(0, 255));
   endfunction

   function automatic logic [POS_IN_W-1:0] any_pos();
      return POS_IN_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [CHAR_W-1:0] any_char();
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   task automatic run_random_items(int count);
      int                pick;
      int                ctl;
      logic [CHAR_W-1:0] ch;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            // text with a mix of control characters
            ctl = $urandom_range(0, 99);
            if (ctl < 8)       ch = CH_NEWLINE;
            else if (ctl < 12) ch = CH_RETURN;
            else if (ctl < 18) ch = CH_BACKSPACE;
            else if (ctl < 23) ch = CH_TAB;
            else               ch = any_char();
            send_item(MODE_PUT, ch, any_pos(), any_pos());
         end else if (pick < 73) begin
            send_item(MODE_SET, any_char(), aim_pos(ROWS), aim_pos(COLS));
         end else if (pick < 98) begin
            send_item(MODE_READ, any_char(), aim_pos(ROWS), aim_pos(COLS));
         end else begin
            send_item(MODE_CLEAR, any_char(), any_pos(), any_pos());
         end
      end
   endtask

   // Stimulus and verdict
   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_FORE_COLOR;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.mode      = MODE_PUT;
      req_bus.char_code = '0;
      req_bus.row_in    = '0;
      req_bus.col_in    = '0;
      hold_requests     = 0;
      send_idle_pct     = 22;
      recv_idle_pct     = 59;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: reset contents, edge bytes, control characters, wraps, scrolls
      send_item(MODE_READ,  8'h00, 8'd0,   8'd0);
      send_item(MODE_READ,  8'hFF, 8'd255, 8'd255);
      send_item(MODE_PUT,   8'h41, 8'd0,   8'd0);
      send_item(MODE_PUT,   8'h00, 8'd0,   8'd0);
      send_item(MODE_PUT,   8'hFF, 8'd255, 8'd255);
      send_item(MODE_PUT,   CH_BACKSPACE, 8'd0, 8'd0);
      send_item(MODE_PUT,   CH_TAB,       8'd0, 8'd0);
      send_item(MODE_PUT,   CH_RETURN,    8'd0, 8'd0);
      send_item(MODE_PUT,   CH_BACKSPACE, 8'd0, 8'd0);
      send_item(MODE_READ,  8'h00, 8'd0,   8'd1);
      send_item(MODE_SET,   8'h00, 8'd0,   8'd79);
      send_item(MODE_PUT,   8'h78, 8'd0,   8'd0);
      send_item(MODE_PUT,   CH_BACKSPACE, 8'd0, 8'd0);
      send_item(MODE_SET,   8'h00, 8'd255, 8'd255);
      send_item(MODE_PUT,   8'h5A, 8'd0,   8'd0);
      send_item(MODE_SET,   8'h00, 8'd24,  8'd0);
      send_item(MODE_PUT,   CH_NEWLINE,   8'd0, 8'd0);
      send_item(MODE_SET,   8'h00, 8'd24,  8'd75);
      send_item(MODE_PUT,   CH_TAB,       8'd0, 8'd0);
      send_item(MODE_SET,   8'h00, 8'd200, 8'd70);
      send_item(MODE_PUT,   CH_TAB,       8'd0, 8'd0);
      send_item(MODE_READ,  8'h00, 8'd23,  8'd79);
      send_item(MODE_CLEAR, 8'h00, 8'd0,   8'd0);
      send_item(MODE_READ,  8'h00, 8'd10,  8'd10);
      wait_drained();

      // sender idles less than the receiver
      set_colors(4'hF, 4'hF);
      run_random_items(480);
      wait_drained();

      // receiver idles less than the sender
      send_idle_pct = 59;
      recv_idle_pct = 22;
      set_colors(4'h0, 4'h0);
      run_random_items(480);
      wait_drained();

      // no idling; one long response hold-off to back up the request side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
      hold_requests = 1;
      run_random_items(490);
      wait_drained();

      repeat (DRAIN_WAIT) @(negedge clock);
      if (fail_count == 0) begin
         $display("text_console_writer_tb: PASS");
      end else begin
         $display("text_console_writer_tb: FAIL");
      end
      $finish;
   end

endmodule
